FILE: sv/sgc1d_pkg.sv
// ----------------------------------------------------------------------------
// sgc1d_pkg
// Shared constants, codes and helpers of the streaming grouped convolution.
// ----------------------------------------------------------------------------
package sgc1d_pkg;

  localparam int MAX_IN_CHANNELS  = 64;
  localparam int MAX_OUT_CHANNELS = 64;
  localparam int MAX_KERNEL       = 16;
  localparam int MAX_STRIDE       = 16;
  localparam int WEIGHT_DEPTH     = 65536;
  localparam int BIAS_DEPTH       = 64;
  localparam int WINDOW_DEPTH     = MAX_KERNEL * MAX_IN_CHANNELS;
  localparam int PROD_SHIFT       = 14;
  localparam int ACC_W            = 44;

  typedef enum logic [2:0] {
    CMD_LOAD_WEIGHT = 3'd0,
    CMD_LOAD_BIAS   = 3'd1,
    CMD_START       = 3'd2,
    CMD_SAMPLE      = 3'd3,
    CMD_ZERO_FRAME  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_IN_CH    = 3'd0,
    REG_OUT_CH   = 3'd1,
    REG_GROUPS   = 3'd2,
    REG_KERNEL   = 3'd3,
    REG_STRIDE   = 3'd4
  } reg_idx_t;

  // zero counts as one, large values saturate
  function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] maxv);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] maxv);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // floor(64 / x) for x in 1..64, found by a search over the quotient
  function automatic logic [6:0] div64(input logic [6:0] x);
    logic [6:0] r;
    logic [13:0] p;
    r = 7'd1;
    for (int q = 1; q <= 64; q++) begin
      p = 14'(q) * {7'd0, x};
      if (p <= 14'd64) r = 7'(q);
    end
    return r;
  endfunction

endpackage

FILE: sv/sgc1d_ram.sv
// ----------------------------------------------------------------------------
// sgc1d_ram
// Generic one-write one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sgc1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/streaming_grouped_conv1d.sv
// ----------------------------------------------------------------------------
// streaming_grouped_conv1d
// Streaming grouped 1D convolution with shared weight and bias tables.
// ----------------------------------------------------------------------------
// Loads, start commands and samples that do not close a frame are taken
// while idle. A frame that triggers output runs one MAC unit over the weight
// and window memories: each output channel goes through a bias read, K*Cg
// MAC issues, a drain of the product and accumulate registers and a hand-off
// to the output register, which waits while the output stalls.
// The block takes no new request until the last result of a frame sits in
// the output register. A zero frame only marks its window slot, so no
// clearing pass is needed at any time.
module streaming_grouped_conv1d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] table_address, [31:16] data_value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [37:32] out_channel, zeros
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import sgc1d_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BIAS  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] cg_raw_r, og_raw_r, g_raw_r;
  logic [4:0] k_raw_r, s_raw_r;

  logic [6:0] cg, og, g1, g2, g_eff, nch;
  logic [4:0] k, s;
  logic [13:0] gcg, gog;

  always_comb begin
    cg  = clamp7(cg_raw_r, 7'd64);
    og  = clamp7(og_raw_r, 7'd64);
    g1  = clamp7(g_raw_r, 7'd64);
    k   = clamp5(k_raw_r, 5'd16);
    s   = clamp5(s_raw_r, 5'd16);
    gcg = {7'd0, g1} * {7'd0, cg};
    g2  = (gcg > 14'd64) ? div64(cg) : g1;
    gog = {7'd0, g2} * {7'd0, og};
    g_eff = (gog > 14'd64) ? div64(og) : g2;
    nch = 7'(({7'd0, g_eff} * {7'd0, cg}));
  end

  logic [2:0]  cmd;
  logic [15:0] addr;
  logic [15:0] data;
  logic        acc_in;
  assign cmd    = in_tuser;
  assign addr   = in_tdata[15:0];
  assign data   = in_tdata[31:16];
  assign in_tready = (state_r == ST_IDLE);
  assign acc_in = in_tvalid && in_tready;

  logic restart;
  assign restart = (cfg_we && cfg_index <= REG_STRIDE) || (acc_in && cmd == CMD_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cg_raw_r <= 7'd1;
      og_raw_r <= 7'd1;
      g_raw_r  <= 7'd1;
      k_raw_r  <= 5'd1;
      s_raw_r  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_CH:  cg_raw_r <= cfg_wdata;
        REG_OUT_CH: og_raw_r <= cfg_wdata;
        REG_GROUPS: g_raw_r  <= cfg_wdata;
        REG_KERNEL: k_raw_r  <= cfg_wdata[4:0];
        REG_STRIDE: s_raw_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // stream position
  logic [6:0]  chpos_r, chpos_nxt, chpos_w;
  logic [3:0]  head_r, head_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] zmark_r, zmark_nxt;
  logic        frame_done, emit;

  always_comb begin
    chpos_nxt  = chpos_r;
    head_nxt   = head_r;
    seen_nxt   = seen_r;
    phase_nxt  = phase_r;
    zmark_nxt  = zmark_r;
    frame_done = 1'b0;
    chpos_w    = (chpos_r >= nch) ? 7'd0 : chpos_r;
    if (acc_in && cmd == CMD_SAMPLE) begin
      zmark_nxt[head_r] = 1'b0;
      chpos_nxt = chpos_w + 7'd1;
      if (chpos_nxt >= nch) frame_done = 1'b1;
    end else if (acc_in && cmd == CMD_ZERO_FRAME) begin
      zmark_nxt[head_r] = 1'b1;
      frame_done = 1'b1;
    end
    if (frame_done) begin
      chpos_nxt = 7'd0;
      head_nxt  = head_r + 4'd1;
      if (seen_r >= k) begin
        phase_nxt = ({1'b0, phase_r} + 5'd1 == s) ? 4'd0 : phase_r + 4'd1;
      end else begin
        seen_nxt  = seen_r + 5'd1;
        phase_nxt = 4'd0;
      end
    end
    emit = frame_done && (seen_nxt >= k) && (phase_nxt == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      chpos_r <= 7'd0;
      head_r  <= 4'd0;
      seen_r  <= 5'd0;
      phase_r <= 4'd0;
    end else begin
      chpos_r <= chpos_nxt;
      head_r  <= head_nxt;
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
    end
    if (!rst_n) zmark_r <= 16'd0;
    else        zmark_r <= zmark_nxt;
  end

  // sequencer counters
  logic [5:0]  c_r, o_r, d_r, chbase_r;
  logic [3:0]  ts_r, fs_r;
  logic [15:0] wa_r;
  logic        v1_r, v2_r, z1_r, ldb_r;
  logic        issue, last_issue, last_out, push;
  logic [6:0]  cg_m1, og_m1, g_m1;
  logic [4:0]  k_m1;

  assign cg_m1 = cg - 7'd1;
  assign og_m1 = og - 7'd1;
  assign g_m1  = g_eff - 7'd1;
  assign k_m1  = k - 5'd1;
  assign issue = (state_r == ST_MAC);
  assign last_issue = ({1'b0, c_r} == cg_m1) && ({1'b0, ts_r} == k_m1);
  assign last_out = ({1'b0, o_r} == og_m1) && ({1'b0, d_r} == g_m1);
  assign push = (state_r == ST_PUSH) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (emit) state_nxt = ST_BIAS;
      ST_BIAS:  state_nxt = ST_MAC;
      ST_MAC:   if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!v1_r && !v2_r) state_nxt = ST_PUSH;
      ST_PUSH:  if (push) state_nxt = last_out ? ST_IDLE : ST_BIAS;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      ldb_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      ldb_r   <= (state_r == ST_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= zmark_r[fs_r];
    if (state_r == ST_IDLE) begin
      o_r      <= 6'd0;
      d_r      <= 6'd0;
      chbase_r <= 6'd0;
      wa_r     <= 16'd0;
      c_r      <= 6'd0;
      ts_r     <= 4'd0;
      fs_r     <= head_nxt - k[3:0];
    end else if (issue) begin
      wa_r <= wa_r + 16'd1;
      if ({1'b0, c_r} == cg_m1) begin
        c_r  <= 6'd0;
        ts_r <= ts_r + 4'd1;
        fs_r <= fs_r + 4'd1;
      end else begin
        c_r <= c_r + 6'd1;
      end
    end else if (push && !last_out) begin
      c_r  <= 6'd0;
      ts_r <= 4'd0;
      fs_r <= head_r - k[3:0];
      if ({1'b0, o_r} == og_m1) begin
        o_r      <= 6'd0;
        d_r      <= d_r + 6'd1;
        chbase_r <= chbase_r + cg[5:0];
        wa_r     <= 16'd0;
      end else begin
        o_r <= o_r + 6'd1;
      end
    end
  end

  // memories
  logic [15:0] w_rdata, b_rdata, x_rdata;
  logic [9:0]  win_raddr, win_waddr;
  logic [5:0]  chan_sel;

  assign chan_sel  = chbase_r + c_r;
  assign win_raddr = {fs_r, chan_sel};
  assign win_waddr = {head_r, chpos_w[5:0]};

  sgc1d_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight (
    .clk   (clk),
    .we    (acc_in && cmd == CMD_LOAD_WEIGHT),
    .waddr (addr),
    .wdata (data),
    .raddr (wa_r),
    .rdata (w_rdata)
  );

  sgc1d_ram #(.WIDTH(16), .DEPTH(BIAS_DEPTH)) u_bias (
    .clk   (clk),
    .we    (acc_in && cmd == CMD_LOAD_BIAS && addr < 16'(BIAS_DEPTH)),
    .waddr (addr[5:0]),
    .wdata (data),
    .raddr (o_r),
    .rdata (b_rdata)
  );

  sgc1d_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (acc_in && cmd == CMD_SAMPLE),
    .waddr (win_waddr),
    .wdata (data),
    .raddr (win_raddr),
    .rdata (x_rdata)
  );

  // MAC datapath
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [15:0]      x_val;

  assign x_val = z1_r ? 16'sd0 : $signed(x_rdata);

  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= x_val * $signed(w_rdata);
    if (ldb_r) begin
      acc_r <= ACC_W'($signed(b_rdata)) <<< PROD_SHIFT;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  logic signed [ACC_W-1:0] q;
  logic [31:0]             sat;
  always_comb begin
    q = acc_r >>> PROD_SHIFT;
    if (q > ACC_W'(64'sh7FFFFFFF))       sat = 32'h7FFFFFFF;
    else if (q < -ACC_W'(64'sh80000000)) sat = 32'h80000000;
    else                                 sat = q[31:0];
  end

  // output register
  logic        ovalid_r;
  logic [31:0] oval_r;
  logic [5:0]  och_r;
  logic        olast_r;
  logic [6:0]  och_full;

  assign och_full = 7'({1'b0, d_r} * og + {1'b0, o_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (push) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
    if (push) begin
      oval_r  <= sat;
      och_r   <= och_full[5:0];
      olast_r <= last_out;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, och_r, oval_r};
  assign out_tlast  = olast_r;

endmodule
